// File: rtl/divisor_count_macros.svh
// ----------------------------------------------------------------------------
// Divisor count assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef DIVISOR_COUNT_MACROS_SVH
`define DIVISOR_COUNT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define DC_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dc_pkg.sv
// ----------------------------------------------------------------------------
// Divisor count package
// Width and saturation limit of the divisor total.
// ----------------------------------------------------------------------------
package dc_pkg;

  // Width of the divisor total and the value at which it saturates.
  localparam int TOTAL_W = 11;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

endpackage

// File: rtl/dc_divider.sv
// ----------------------------------------------------------------------------
// Divisor count divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dc_divider #(
  parameter int DIVIDEND_W = 32,
  parameter int DIVISOR_W  = 17
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic [DIVISOR_W-1:0]  remainder
);

  localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIVIDEND_W-1:0] dq;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // One restoring step: shift in the next dividend bit and try the subtract.
  always_comb begin
    rem_sh = {rem, dq[DIVIDEND_W-1]};
    diff   = rem_sh - {1'b0, divisor};
    fits   = rem_sh >= {1'b0, divisor};
  end

  // The quotient bits replace the dividend bits as they shift out.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(DIVIDEND_W - 1);
      dq   <= dividend;
      rem  <= '0;
    end else if (busy) begin
      rem <= fits ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      dq  <= {dq[DIVIDEND_W-2:0], fits};
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign quotient  = dq;
  assign remainder = rem;

endmodule

// File: rtl/divisor_count.sv
// Operation: each trial division runs in the shared divider, and an item needs one
// division per candidate factor plus one per prime factor found (counted with
// multiplicity); a 32-bit prime needs about 65536 divisions.
// Throughput: one word at a time; in_ready is high only while no word is being worked on.
// Reset (rst, synchronous, active high) clears the sequencer, divider and output valid.
// ----------------------------------------------------------------------------
// Divisor count
// Counts the positive divisors of a value by trial division with a
// bit-serial divider, multiplying the count by (exponent + 1) per prime.
// ----------------------------------------------------------------------------
module divisor_count #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [VALUE_WIDTH-1:0]      value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dc_pkg::TOTAL_W-1:0]  divisor_total
);

  import dc_pkg::*;

  `include "divisor_count_macros.svh"

  // Factor wide enough to pass the square root of the largest value.
  localparam int FACTOR_W = (VALUE_WIDTH + 1) / 2 + 1;
  localparam int EXP_W    = $clog2(VALUE_WIDTH + 2);
  localparam int PROD_W   = TOTAL_W + EXP_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FINISH
  } state_t;

  state_t                 state;
  logic [VALUE_WIDTH-1:0] rest;
  logic [FACTOR_W-1:0]    factor;
  logic [EXP_W-1:0]       exp_cnt;
  logic                   inner;
  logic [TOTAL_W-1:0]     total;
  logic                   div_start;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] quotient;
  logic [FACTOR_W-1:0]    remainder;

  logic [EXP_W-1:0]       exp_inc;
  logic [PROD_W-1:0]      prod;
  logic [TOTAL_W-1:0]     total_next;
  logic [TOTAL_W-1:0]     total_dbl;
  logic                   factor_past;
  logic                   rem_zero;

  // Shared divider: rest divided by the current factor.
  dc_divider #(
    .DIVIDEND_W (VALUE_WIDTH),
    .DIVISOR_W  (FACTOR_W)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (rest),
    .divisor   (factor),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (remainder)
  );

  // Count update for a finished prime and the final doubling, both saturating.
  always_comb begin
    exp_inc     = exp_cnt + 1'b1;
    prod        = PROD_W'(total) * PROD_W'(exp_inc);
    total_next  = (prod > PROD_W'(TOTAL_MAX)) ? TOTAL_MAX : prod[TOTAL_W-1:0];
    total_dbl   = total[TOTAL_W-1] ? TOTAL_MAX : {total[TOTAL_W-2:0], 1'b0};
    factor_past = VALUE_WIDTH'(factor) > quotient;
    rem_zero    = remainder == '0;
  end

  assign in_ready = (state == S_IDLE);

  // Sequencer: one division per step, outer test and inner repeat share it.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state != S_FINISH && out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          div_start <= in_valid;
          if (in_valid) begin
            rest      <= value;
            factor    <= FACTOR_W'(2);
            exp_cnt   <= '0;
            inner     <= 1'b0;
            total     <= TOTAL_W'(1);
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          // Every finished division starts another unless the loop is over.
          div_start <= div_done && (inner || !factor_past);
          if (div_done) begin
            if (!inner && factor_past) begin
              // Factor squared exceeds what remains: the loop is over.
              state <= S_FINISH;
            end else if (rem_zero) begin
              // Factor divides again: take it out and retry the same factor.
              rest      <= quotient;
              exp_cnt   <= exp_cnt + 1'b1;
              inner     <= 1'b1;
            end else begin
              // Move to the next candidate, folding in any exponent found.
              if (inner) begin
                total <= total_next;
              end
              factor    <= factor + 1'b1;
              exp_cnt   <= '0;
              inner     <= 1'b0;
            end
          end
        end
        S_FINISH: begin
          div_start <= 1'b0;
          if (!out_valid || out_ready) begin
            // A leftover above one is one more prime.
            divisor_total <= (rest > VALUE_WIDTH'(1)) ? total_dbl : total;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          div_start <= 1'b0;
          state     <= S_IDLE;
        end
      endcase
    end
  end

  // Checks on the sequencer and divider handoff.
  `DC_ASSERT_NEXT(a_accept_starts, clk, rst, in_valid && in_ready,
                  div_start && state == S_DIV, "accepted word did not start a division")
  `DC_ASSERT_NOW(a_done_in_div, clk, rst, div_done, state == S_DIV,
                 "divider finished outside the division state")
  `DC_ASSERT_NOW(a_factor_min, clk, rst, state == S_DIV, factor >= FACTOR_W'(2),
                 "trial factor below two")
  `DC_ASSERT_NOW(a_total_nonzero, clk, rst, out_valid, divisor_total != '0,
                 "divisor total of zero")

endmodule
